FILE: src/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the affine point transform and plot block.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int COEF_W    = 20;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int OFF_W     = 20;
    localparam int DIM_W     = 9;
    localparam int AREA_W    = 2 * DIM_W;
    localparam int PNT_W     = 16;
    localparam int PROD_W    = COEF_W + PNT_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_BITS = 22;
    localparam int OFF_SHIFT = 14;
    localparam int COORD_W   = 16;
    localparam int SCALE_W   = COORD_W + DIM_W + 1;
    localparam int IDX_W     = SCALE_W + 1;
    localparam int ADDR_W    = 3;

    localparam logic [COORD_W-1:0] ATTR_BASE = 16'd10;
    localparam logic [COORD_W-1:0] ATTR_RED  = 16'd4;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    // items that can be inside the front at once, including the one being taken
    localparam int FRONT_SLOTS = 4;

    typedef enum logic [ADDR_W-1:0] {
        REG_ROW_X    = 3'd0,
        REG_ROW_Y    = 3'd1,
        REG_ROW_Z    = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [PNT_W-1:0] point_x;
        logic signed [PNT_W-1:0] point_y;
        logic signed [PNT_W-1:0] point_z;
        logic                    last_point;
    } point_t;

    typedef struct packed {
        logic                plotted;
        logic [COORD_W-1:0]  cell_index;
        logic [COORD_W-1:0]  attribute;
        logic                last_result;
    } result_t;

    typedef struct packed {
        logic [ROW_W-1:0]        row_x;
        logic [ROW_W-1:0]        row_y;
        logic [ROW_W-1:0]        row_z;
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic signed [OFF_W-1:0] off_z;
        logic [DIM_W-1:0]        width;
        logic [AREA_W-1:0]       area;
    } cfg_t;

    // transformed point waiting for the screen stage
    typedef struct packed {
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
        logic                      last;
    } xform_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] level;
    } queue_status_t;

endpackage

FILE: src/affine_point_transform_plot_top.sv
// ----------------------------------------------------------------------------
// affine_point_transform_plot_top
// Affine 3D point transform with screen cell index and attribute output.
// ----------------------------------------------------------------------------
// a taken item passes the s1, s2 and s3 registers, the queue, b1 and the done register before done rises
// throughput: one item per cycle while busy is low, set by the three-stage multiply/add front
// and the two-stage screen back, both fully pipelined
// the receiver cannot stall; the queue between front and back never fills
// reset clears the pipeline and queue and loads default transform and 80x25
module affine_point_transform_plot_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  apt_pkg::point_t            point,
    output logic                       busy,
    output logic                       done,
    output apt_pkg::result_t           result,
    input  logic                       cfg_we,
    input  logic [apt_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [apt_pkg::ROW_W-1:0]  cfg_data
);
    import apt_pkg::*;

    cfg_t          cfg;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    xform_t        push_data;
    xform_t        head;

    apt_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    apt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .point     (point),
        .cfg       (cfg),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    apt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    apt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .cfg      (cfg),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

endmodule

FILE: src/apt_cfg.sv
// ----------------------------------------------------------------------------
// apt_cfg
// Configuration registers, screen size clamping and screen area.
// ----------------------------------------------------------------------------
module apt_cfg #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [apt_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [apt_pkg::ROW_W-1:0]    cfg_data,
    output apt_pkg::cfg_t                cfg
);
    import apt_pkg::*;

    localparam int RST_W    = (80 > MAX_WIDTH) ? MAX_WIDTH : 80;
    localparam int RST_H    = (25 > MAX_HEIGHT) ? MAX_HEIGHT : 25;
    localparam int RST_AREA = RST_W * RST_H;
    localparam int CMP_W    = 11;

    logic [ROW_W-1:0]  row_x_reg, row_y_reg, row_z_reg;
    logic [OFF_W-1:0]  off_x_reg, off_y_reg, off_z_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [DIM_W-1:0]  width_eff, height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg  <= ROW_W'(60'd16384);
            row_y_reg  <= ROW_W'(60'd16384) << COEF_W;
            row_z_reg  <= ROW_W'(60'd16384) << (2 * COEF_W);
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            off_z_reg  <= '0;
            width_reg  <= DIM_W'(80);
            height_reg <= DIM_W'(25);
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_ROW_X:    row_x_reg  <= cfg_data;
                REG_ROW_Y:    row_y_reg  <= cfg_data;
                REG_ROW_Z:    row_z_reg  <= cfg_data;
                REG_OFFSET_X: off_x_reg  <= cfg_data[OFF_W-1:0];
                REG_OFFSET_Y: off_y_reg  <= cfg_data[OFF_W-1:0];
                REG_OFFSET_Z: off_z_reg  <= cfg_data[OFF_W-1:0];
                REG_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    // saturate to 1 .. max
    always_comb
    begin
        if (width_reg == '0)
            width_eff = DIM_W'(1);
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
            width_eff = DIM_W'(MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = DIM_W'(1);
        else if (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT))
            height_eff = DIM_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    assign area_next = AREA_W'(width_eff) * AREA_W'(height_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            area_reg <= AREA_W'(RST_AREA);
        else
            area_reg <= area_next;
    end

    always_comb
    begin
        cfg.row_x = row_x_reg;
        cfg.row_y = row_y_reg;
        cfg.row_z = row_z_reg;
        cfg.off_x = $signed(off_x_reg);
        cfg.off_y = $signed(off_y_reg);
        cfg.off_z = $signed(off_z_reg);
        cfg.width = width_eff;
        cfg.area  = area_reg;
    end

endmodule

FILE: src/apt_front.sv
// ----------------------------------------------------------------------------
// apt_front
// Takes points and runs the 3x3 affine transform plus offsets, truncating
// each axis toward zero, then pushes the result into the queue.
// ----------------------------------------------------------------------------
module apt_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  apt_pkg::point_t        point,
    input  apt_pkg::cfg_t          cfg,
    input  apt_pkg::queue_status_t q_status,
    output logic                   busy,
    output logic                   push,
    output apt_pkg::xform_t        push_data
);
    import apt_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    logic   take;
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg;
    point_t s1_point_reg;
    prod_t  s2_prod_reg [9];
    logic   s2_last_reg;
    acc_t   s3_acc_reg [3];
    logic   s3_last_reg;
    acc_t   acc_next [3];
    logic [ROW_W-1:0]        rows [3];
    logic signed [OFF_W-1:0] offs [3];
    logic signed [PNT_W-1:0] pts [3];
    logic signed [COORD_W-1:0] coord [3];

    // room for every item that may still be in flight ahead of the queue
    assign busy = q_status.level > QCNT_W'(QUEUE_DEPTH - FRONT_SLOTS);
    assign take = start && !busy;

    assign rows[0] = cfg.row_x;
    assign rows[1] = cfg.row_y;
    assign rows[2] = cfg.row_z;
    assign offs[0] = cfg.off_x;
    assign offs[1] = cfg.off_y;
    assign offs[2] = cfg.off_z;
    assign pts[0]  = s1_point_reg.point_x;
    assign pts[1]  = s1_point_reg.point_y;
    assign pts[2]  = s1_point_reg.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_point_reg <= point;
    end

    // nine products, axis a uses slots 3a .. 3a+2
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_prod_reg[3*a+k] <= $signed(rows[a][COEF_W*k +: COEF_W]) * pts[k];
            end
        end
        s2_last_reg <= s1_point_reg.last_point;
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            acc_next[a] = ACC_W'(s2_prod_reg[3*a]) + ACC_W'(s2_prod_reg[3*a+1])
                        + ACC_W'(s2_prod_reg[3*a+2])
                        + (ACC_W'(offs[a]) <<< OFF_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            s3_acc_reg[a] <= acc_next[a];
        end
        s3_last_reg <= s2_last_reg;
    end

    // floor shift, plus one when a negative value had fraction bits
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            coord[a] = COORD_W'(s3_acc_reg[a] >>> FRAC_BITS);
            if (s3_acc_reg[a][ACC_W-1] && (s3_acc_reg[a][FRAC_BITS-1:0] != '0))
                coord[a] = coord[a] + COORD_W'(1);
        end
    end

    assign push         = s3_valid_reg;
    assign push_data.tx = coord[0];
    assign push_data.ty = coord[1];
    assign push_data.tz = coord[2];
    assign push_data.last = s3_last_reg;

endmodule

FILE: src/apt_queue.sv
// ----------------------------------------------------------------------------
// apt_queue
// Short FIFO between the transform front and the screen back.
// ----------------------------------------------------------------------------
module apt_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  apt_pkg::xform_t        push_data,
    input  logic                   pop,
    output apt_pkg::xform_t        head,
    output apt_pkg::queue_status_t status
);
    import apt_pkg::*;

    xform_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.level = count_reg;

endmodule

FILE: src/apt_back.sv
// ----------------------------------------------------------------------------
// apt_back
// Turns a transformed point into a screen cell index, hit flag and attribute.
// ----------------------------------------------------------------------------
module apt_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  apt_pkg::queue_status_t q_status,
    input  apt_pkg::xform_t        head,
    input  apt_pkg::cfg_t          cfg,
    output logic                   pop,
    output logic                   done,
    output apt_pkg::result_t       result
);
    import apt_pkg::*;

    logic                      b1_valid_reg;
    logic signed [SCALE_W-1:0] b1_row_off_reg;
    logic signed [COORD_W-1:0] b1_tx_reg;
    logic signed [COORD_W-1:0] b1_tz_reg;
    logic                      b1_last_reg;

    logic                      done_reg;
    result_t                   result_reg, result_next;

    logic signed [IDX_W-1:0]   idx;
    logic                      hit;

    // the back never stalls, so it drains one item each cycle while the queue is not empty
    assign pop = !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= pop;
            done_reg     <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_row_off_reg <= $signed({1'b0, cfg.width}) * head.ty;
            b1_tx_reg      <= head.tx;
            b1_tz_reg      <= head.tz;
            b1_last_reg    <= head.last;
        end
    end

    always_comb
    begin
        idx = IDX_W'(b1_tx_reg) + IDX_W'(b1_row_off_reg);
        hit = !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(cfg.area));

        result_next.plotted     = hit;
        result_next.last_result = b1_last_reg;
        if (hit)
        begin
            result_next.cell_index = idx[COORD_W-1:0];
            result_next.attribute  = (b1_tz_reg + ATTR_BASE) | ATTR_RED;
        end
        else
        begin
            result_next.cell_index = '0;
            result_next.attribute  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
